// File: src/gaussian_pyramid_downsample_top_macros.svh
// Assertion macros for the pyramid reduce block.
// Expects clk_i and rst_ni in the scope where they are used.
`ifndef GAUSSIAN_PYRAMID_DOWNSAMPLE_TOP_MACROS_SVH
`define GAUSSIAN_PYRAMID_DOWNSAMPLE_TOP_MACROS_SVH

// ante implies cons on the same edge
`define GPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cond never holds
`define GPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: src/gpd_pkg.sv
// Shared types and constants of the pyramid reduce block.
// No dependencies.
`timescale 1ns / 1ps

package gpd_pkg;

  localparam int PIX_W       = 8;
  localparam int OUT_W       = 16;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int ROW_W       = CFG_W + 1;
  localparam int VSUM_W      = 12;
  localparam int TAPS        = 5;
  localparam int LINE_STORES = 4;
  localparam int SLOT_W      = $clog2(LINE_STORES);
  localparam int WIN_LEN     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] IMG_W_RST = 11'd640;
  localparam logic [CFG_W-1:0] IMG_H_RST = 11'd480;
  localparam logic [CFG_W-1:0] MIN_DIM   = 11'd3;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // binomial taps 1 4 6 4 1
  localparam logic [VSUM_W-1:0] TAP_W [TAPS] = '{12'd1, 12'd4, 12'd6, 12'd4, 12'd1};
  localparam logic [OUT_W-1:0] W_OUTER  = 16'd1;
  localparam logic [OUT_W-1:0] W_INNER  = 16'd4;
  localparam logic [OUT_W-1:0] W_CENTER = 16'd6;

  typedef logic [SLOT_W-1:0] slot_t;

  // one column of an active row, vertical sum done
  typedef struct packed {
    logic [VSUM_W-1:0] vsum;
    logic              emit_first;
    logic              first_left;
    logic              emit_second;
    logic              second_odd;
    logic              last_row;
  } col_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_pixel;
    logic             row_end;
    logic             frame_end;
  } res_word_t;

endpackage

// File: src/gpd_in_if.sv
// Input word channel: valid/ready with op and pixel.
// Depends on gpd_pkg.
`timescale 1ns / 1ps

interface gpd_in_if import gpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

// File: src/gpd_out_if.sv
// Result word channel: valid/ready with filtered pixel and end flags.
// Depends on gpd_pkg.
`timescale 1ns / 1ps

interface gpd_out_if import gpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] out_pixel;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output out_pixel, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_pixel, input row_end, input frame_end,
                  output ready);
endinterface

// File: src/gpd_fifo.sv
// Short queue of column words between front and back.
// Depends on gpd_pkg. Pushes are credited by the front, never when full.
`timescale 1ns / 1ps

module gpd_fifo import gpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  col_word_t         push_word_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output col_word_t         head_word_o,
  output logic [QCNT_W-1:0] count_o
);

  col_word_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_word_o  = mem_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

// File: src/gpd_front.sv
// Front: config registers, frame counters, line memory and vertical filter.
// Depends on gpd_pkg and gpd_in_if; feeds column words to gpd_fifo.
`timescale 1ns / 1ps

module gpd_front import gpd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  gpd_in_if.sink               in_i,
  input  logic [QCNT_W-1:0]    q_count_i,
  output logic                 push_valid_o,
  output col_word_t            push_word_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CW = QCNT_W + 1;

  logic [CFG_W-1:0] img_w_q, img_h_q;
  logic [XW-1:0]    w_ext;
  logic [WW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h, h_m1, last_even;

  logic [AW-1:0]    col_q, col_d;
  logic [CFG_W-1:0] row_q, row_d;
  logic             half_q, half_d;

  logic             flush_ph, is_pix, take, active, col_last, mem_we, top_row;
  logic [ROW_W-1:0] row_r;
  slot_t            r_lo, h_lo, bot_lo;
  slot_t            slot_d [TAPS];

  logic [PIX_W-1:0] rd_q [LINE_STORES];

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_use_pix_q;
  slot_t            s1_slot_q [TAPS];
  logic             s1_emit_first_q, s1_first_left_q, s1_emit_second_q;
  logic             s1_second_odd_q, s1_last_row_q;

  logic [PIX_W-1:0]  tap_pix;
  logic [VSUM_W-1:0] vsum;

  // effective frame size
  assign w_ext = XW'(img_w_q);
  always_comb begin
    if (w_ext < XW'(MIN_DIM)) begin
      eff_w = WW'(MIN_DIM);
    end else if (w_ext > XW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(w_ext);
    end
  end
  assign eff_h     = (img_h_q < MIN_DIM) ? MIN_DIM : img_h_q;
  assign h_m1      = eff_h - CFG_W'(1);
  assign last_even = {h_m1[CFG_W-1:1], 1'b0};

  // classify the word
  assign flush_ph = (row_q >= eff_h);
  assign is_pix   = (in_i.op == OP_PIXEL);
  assign take     = in_i.valid && in_i.ready && (is_pix ? !flush_ph : flush_ph);
  assign row_r    = is_pix ? ROW_W'(row_q) : ROW_W'(eff_h) + ROW_W'(half_q);
  assign active   = take && (row_r >= ROW_W'(2)) && !row_r[0];
  assign col_last = (WW'(col_q) == eff_w - WW'(1));
  assign mem_we   = take && is_pix;

  // line slot of each vertical tap, rows mirrored at top and bottom
  assign r_lo    = row_r[SLOT_W-1:0];
  assign h_lo    = eff_h[SLOT_W-1:0];
  assign bot_lo  = SLOT_W'(eff_h << 1) - SLOT_W'(1) - r_lo;
  assign top_row = (row_r == ROW_W'(2));

  always_comb begin
    slot_d[0] = top_row ? SLOT_W'(1) : r_lo;
    slot_d[1] = top_row ? SLOT_W'(0) : r_lo + SLOT_W'(1);
    slot_d[2] = r_lo + SLOT_W'(2);
    slot_d[3] = (row_r > ROW_W'(eff_h)) ? h_lo - SLOT_W'(1) : r_lo - SLOT_W'(1);
    slot_d[4] = (row_r >= ROW_W'(eff_h)) ? bot_lo : r_lo;
  end

  always_comb begin
    col_d  = col_q + AW'(1);
    row_d  = row_q;
    half_d = half_q;
    if (col_last) begin
      col_d = '0;
      if (is_pix) begin
        row_d = row_q + CFG_W'(1);
      end else if (half_q) begin
        row_d  = '0;
        half_d = 1'b0;
      end else begin
        half_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= IMG_W_RST;
      img_h_q    <= IMG_H_RST;
      col_q      <= '0;
      row_q      <= '0;
      half_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= active;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i;
          CFG_IMAGE_HEIGHT: img_h_q <= cfg_wdata_i;
          default: ;
        endcase
        col_q  <= '0;
        row_q  <= '0;
        half_q <= 1'b0;
      end else if (take) begin
        col_q  <= col_d;
        row_q  <= row_d;
        half_q <= half_d;
      end
    end
  end

  // line memory, one bank per stored row: read before write returns the row four back
  for (genvar b = 0; b < LINE_STORES; b++) begin : g_bank
    logic [PIX_W-1:0] line_q [MAX_WIDTH];

    always_ff @(posedge clk_i) begin
      if (active) begin
        rd_q[b] <= line_q[col_q];
      end
      if (mem_we && (r_lo == slot_t'(b))) begin
        line_q[col_q] <= in_i.pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active) begin
      s1_pix_q         <= in_i.pixel;
      s1_use_pix_q     <= is_pix;
      s1_slot_q        <= slot_d;
      s1_emit_first_q  <= (col_q >= AW'(2)) && !col_q[0];
      s1_first_left_q  <= (col_q == AW'(2));
      s1_emit_second_q <= col_last;
      s1_second_odd_q  <= eff_w[0];
      s1_last_row_q    <= (row_r - ROW_W'(2) == ROW_W'(last_even));
    end
  end

  // vertical sum
  always_comb begin
    vsum    = '0;
    tap_pix = '0;
    for (int t = 0; t < TAPS; t++) begin
      tap_pix = (t == TAPS - 1 && s1_use_pix_q) ? s1_pix_q : rd_q[s1_slot_q[t]];
      vsum    = vsum + VSUM_W'(tap_pix) * TAP_W[t];
    end
  end

  assign in_i.ready   = ({1'b0, q_count_i} + CW'(s1_valid_q)) < CW'(QUEUE_DEPTH);
  assign push_valid_o = s1_valid_q;
  assign push_word_o  = '{vsum:        vsum,
                          emit_first:  s1_emit_first_q,
                          first_left:  s1_first_left_q,
                          emit_second: s1_emit_second_q,
                          second_odd:  s1_second_odd_q,
                          last_row:    s1_last_row_q};

endmodule

// File: src/gpd_back.sv
// Back: column sum window, horizontal filter and result register.
// Depends on gpd_pkg and gpd_out_if; drains gpd_fifo.
`timescale 1ns / 1ps

module gpd_back import gpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       restart_i,
  input  logic       head_valid_i,
  input  col_word_t  head_word_i,
  output logic       pop_o,
  gpd_out_if.source  out_o
);

  logic [VSUM_W-1:0] win_q [WIN_LEN];
  logic [OUT_W-1:0]  e0, e1, e2, e3, ev;
  logic [OUT_W-1:0]  h_norm, h_left, h_reven, h_rodd;
  logic              emits, slot_free, pop;
  res_word_t         first_w, second_w;
  logic              out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  res_word_t         out_word_q, out_word_d, pend_word_q, pend_word_d;

  assign e0 = OUT_W'(win_q[0]);
  assign e1 = OUT_W'(win_q[1]);
  assign e2 = OUT_W'(win_q[2]);
  assign e3 = OUT_W'(win_q[3]);
  assign ev = OUT_W'(head_word_i.vsum);

  // mirrored columns fold into neighbouring weights at the edges
  assign h_norm  = W_OUTER * e3 + W_INNER * e2 + W_CENTER * e1 + W_INNER * e0 + W_OUTER * ev;
  assign h_left  = (W_OUTER + W_INNER) * e0 + (W_INNER + W_CENTER) * e1 + W_OUTER * ev;
  assign h_reven = W_OUTER * e2 + W_INNER * e1 + W_CENTER * e0 + (W_INNER + W_OUTER) * ev;
  assign h_rodd  = W_OUTER * e1 + (W_INNER + W_OUTER) * e0 + (W_CENTER + W_INNER) * ev;

  assign first_w  = '{out_pixel: head_word_i.first_left ? h_left : h_norm,
                      row_end: 1'b0, frame_end: 1'b0};
  assign second_w = '{out_pixel: head_word_i.second_odd ? h_rodd : h_reven,
                      row_end: 1'b1, frame_end: head_word_i.last_row};

  assign emits     = head_word_i.emit_first || head_word_i.emit_second;
  assign slot_free = !out_valid_q || out_o.ready;
  assign pop       = head_valid_i && !pend_valid_q && (slot_free || !emits);
  assign pop_o     = pop;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    pend_valid_d = pend_valid_q;
    pend_word_d  = pend_word_q;
    if (slot_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_word_d   = pend_word_q;
        pend_valid_d = 1'b0;
      end else if (pop && head_word_i.emit_first) begin
        out_valid_d = 1'b1;
        out_word_d  = first_w;
        if (head_word_i.emit_second) begin
          pend_valid_d = 1'b1;
          pend_word_d  = second_w;
        end
      end else if (pop && head_word_i.emit_second) begin
        out_valid_d = 1'b1;
        out_word_d  = second_w;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (restart_i) begin
        for (int i = 0; i < WIN_LEN; i++) begin
          win_q[i] <= '0;
        end
      end else if (pop) begin
        win_q[0] <= head_word_i.vsum;
        for (int i = 1; i < WIN_LEN; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    pend_word_q <= pend_word_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_pixel = out_word_q.out_pixel;
  assign out_o.row_end   = out_word_q.row_end;
  assign out_o.frame_end = out_word_q.frame_end;

endmodule

// File: src/gaussian_pyramid_downsample_top.sv
// 5-tap binomial pyramid reduce, 8-bit gray in, 8.8 fixed point out.
// A result word goes through the s1 registers, the column queue and the result register.
// Throughput: one input word per cycle while the column queue has room; at a row end of an
// odd-width frame one input word gives two result words, the second from a hold register.
// Reset: size 640x480, counters and column window cleared; line memory not cleared.
`timescale 1ns / 1ps
`include "gaussian_pyramid_downsample_top_macros.svh"

module gaussian_pyramid_downsample_top import gpd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  gpd_in_if.sink               in_i,
  gpd_out_if.source            out_o
);

  logic              push_valid, head_valid, fifo_pop;
  col_word_t         push_word, head_word;
  logic [QCNT_W-1:0] fifo_count;
  logic              q_full, out_fend;

  gpd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .q_count_i    (fifo_count),
    .push_valid_o (push_valid),
    .push_word_o  (push_word)
  );

  gpd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_word_i  (push_word),
    .pop_i        (fifo_pop),
    .head_valid_o (head_valid),
    .head_word_o  (head_word),
    .count_o      (fifo_count)
  );

  gpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_we_i),
    .head_valid_i (head_valid),
    .head_word_i  (head_word),
    .pop_o        (fifo_pop),
    .out_o        (out_o)
  );

  assign q_full   = (fifo_count == QCNT_W'(QUEUE_DEPTH));
  assign out_fend = out_o.valid && out_o.frame_end;

  `GPD_ASSERT_NEVER(a_queue_no_overflow, push_valid && !fifo_pop && q_full, "queue overflow")
  `GPD_ASSERT_IMP(a_pop_nonempty, fifo_pop, fifo_count != '0, "pop from empty queue")
  `GPD_ASSERT_IMP(a_frame_end_row_end, out_fend, out_o.row_end, "frame end without row end")

endmodule

// File: tb/gpd_reduce_checker.sv
// Scoreboard for the pyramid reduce block: predicts result words from accepted input words
// and register writes, then compares each accepted result word in order.
// Depends on gpd_pkg, gpd_in_if and gpd_out_if.
`timescale 1ns / 1ps

module gpd_reduce_checker import gpd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  gpd_in_if                    in_mon,
  gpd_out_if                   out_mon,
  output int                   mismatch_count_o,
  output int                   pending_words_o
);

  localparam int MAX_REPORTS = 100;

  logic [PIX_W-1:0]  rows_mem [LINE_STORES][MAX_WIDTH];
  logic [VSUM_W-1:0] col_hist [WIN_LEN];
  int                width_reg;
  int                height_reg;
  int                col_pos;
  int                row_pos;
  int                flush_beats;
  int                mismatches;
  res_word_t         expected_words [$];

  function automatic int binom(input int t);
    return (t == 2) ? 6 : ((t == 1 || t == 3) ? 4 : 1);
  endfunction

  // mirror border: -1 -> 0, -2 -> 1, n -> n-1
  function automatic int mirror(input int j, input int n);
    if (j < 0) j = -j - 1;
    if (j >= n) j = 2 * n - 1 - j;
    if (j < 0) j = 0;
    if (j >= n) j = n - 1;
    return j;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < WIN_LEN; i++) col_hist[i] = '0;
    col_pos     = 0;
    row_pos     = 0;
    flush_beats = 0;
  endfunction

  // horizontal taps around column k; cur is the vertical sum at column c
  function automatic logic [OUT_W-1:0] horiz_sum(input int k, input int c, input int w,
                                                 input int cur);
    int acc, j, d, v, t;
    acc = 0;
    for (t = 0; t < TAPS; t++) begin
      j = mirror(k - 2 + t, w);
      d = c - j;
      if (d <= 0) v = cur;
      else if (d > WIN_LEN) v = 0;
      else v = int'(col_hist[d - 1]);
      acc += binom(t) * v;
    end
    return acc[OUT_W-1:0];
  endfunction

  function automatic void predict_reduce(input logic op, input logic [PIX_W-1:0] pix);
    int               w, h, rr, cc, r, j, k, t, vsum;
    logic [PIX_W-1:0] p;
    res_word_t        res;
    w = width_reg;
    if (w < int'(MIN_DIM)) w = int'(MIN_DIM);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg < int'(MIN_DIM)) ? int'(MIN_DIM) : height_reg;
    if (op == OP_PIXEL) begin
      if (row_pos >= h) return;
      rr = row_pos;
      cc = col_pos;
    end else begin
      if (row_pos < h) return;
      rr = (flush_beats >= w) ? h + 1 : h;
      cc = (flush_beats >= w) ? flush_beats - w : flush_beats;
    end
    if (cc >= w) cc = w - 1;

    if (rr >= 2 && (rr % 2) == 0) begin
      r = rr - 2;
      vsum = 0;
      for (t = 0; t < TAPS; t++) begin
        j = mirror(r - 2 + t, h);
        p = (j == rr && op == OP_PIXEL) ? pix : rows_mem[j % LINE_STORES][cc];
        vsum += binom(t) * int'(p);
      end
      if (cc >= 2 && (cc % 2) == 0) begin
        res.out_pixel = horiz_sum(cc - 2, cc, w, vsum);
        res.row_end   = 1'b0;
        res.frame_end = 1'b0;
        expected_words.insert(expected_words.size(), res);
      end
      if (cc == w - 1) begin
        k = (w % 2 == 0) ? w - 2 : w - 1;
        res.out_pixel = horiz_sum(k, cc, w, vsum);
        res.row_end   = 1'b1;
        res.frame_end = (r == ((h - 1) & ~1));
        expected_words.insert(expected_words.size(), res);
      end
      for (t = WIN_LEN - 1; t > 0; t--) col_hist[t] = col_hist[t - 1];
      col_hist[0] = vsum[VSUM_W-1:0];
    end

    if (op == OP_PIXEL) begin
      rows_mem[rr % LINE_STORES][cc] = pix;
      if (cc + 1 >= w) begin
        col_pos = 0;
        row_pos = rr + 1;
      end else begin
        col_pos = cc + 1;
      end
    end else begin
      flush_beats++;
      if (flush_beats >= 2 * w) restart_frame();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_word();
    res_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word out_pixel=%0d row_end=%0b frame_end=%0b",
                                out_mon.out_pixel, out_mon.row_end, out_mon.frame_end));
      return;
    end
    want = expected_words.pop_front();
    if (out_mon.out_pixel !== want.out_pixel)
      report_mismatch($sformatf("out_pixel got %0d want %0d", out_mon.out_pixel,
                                want.out_pixel));
    if (out_mon.row_end !== want.row_end)
      report_mismatch($sformatf("row_end got %0b want %0b", out_mon.row_end, want.row_end));
    if (out_mon.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end got %0b want %0b", out_mon.frame_end,
                                want.frame_end));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = int'(IMG_W_RST);
      height_reg = int'(IMG_H_RST);
      restart_frame();
      expected_words.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_words_o  <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_word();
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IMAGE_WIDTH) width_reg = int'(cfg_wdata_i);
        else height_reg = int'(cfg_wdata_i);
        restart_frame();
      end
      if (in_mon.valid && in_mon.ready) predict_reduce(in_mon.op, in_mon.pixel);
      mismatch_count_o <= mismatches;
      pending_words_o  <= expected_words.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the pyramid reduce testbench: clock, reset, register writes, pixel and flush
// words with random gaps and stalls, and the verdict. Depends on gpd_pkg, both channel
// interfaces, gaussian_pyramid_downsample_top and gpd_reduce_checker.
`timescale 1ns / 1ps

module testbench;
  import gpd_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 450;
  localparam int NONE         = -1;
  localparam int ANYWHERE     = 0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_idx_e             cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  int                   send_idle;
  int                   recv_idle;
  int                   mismatch_count;
  int                   pending_words;
  int                   width_val;
  int                   height_val;
  int                   words_sent;

  gpd_in_if  in_ch ();
  gpd_out_if out_ch ();

  gaussian_pyramid_downsample_top #(.MAX_WIDTH(MAX_WIDTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  gpd_reduce_checker #(.MAX_WIDTH(MAX_WIDTH)) scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatch_count),
    .pending_words_o  (pending_words)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #(64'd10_000_000);
    $display("FAILURE");
    $finish;
  end

  task automatic set_idling(input int s, input int r);
    send_idle <= s;
    recv_idle <= r;
  endtask

  task automatic send_word(input op_e op, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.pixel <= pix;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_val = val;
    else height_val = val;
  endtask

  task automatic configure(input int w, input int h);
    settle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // fill < 0: random pixels. stop_at/pause_at: NONE, ANYWHERE (random) or a word index.
  // A frame cut short is restarted by a register write once idle.
  task automatic send_frame(input int fill, input bit noisy, input int stop_at,
                            input int pause_at);
    int               w, h, total, i;
    logic [PIX_W-1:0] pix;
    w = (width_val < 3) ? 3 : ((width_val > MAX_WIDTH) ? MAX_WIDTH : width_val);
    h = (height_val < 3) ? 3 : height_val;
    total = w * h + 2 * w;
    if (stop_at == ANYWHERE) stop_at = $urandom_range(1, total - 1);
    if (stop_at < 0 || stop_at > total) stop_at = total;
    if (pause_at == ANYWHERE) pause_at = $urandom_range(1, total - 1);
    for (i = 0; i < stop_at; i++) begin
      if (i == pause_at) wait_drained();
      if (i < w * h) begin
        if (noisy && $urandom_range(15) == 0) send_word(OP_FLUSH, PIX_W'($urandom));
        if (fill >= 0) pix = PIX_W'(fill);
        else begin
          case ($urandom_range(7))
            0:       pix = '0;
            1:       pix = '1;
            default: pix = PIX_W'($urandom);
          endcase
        end
        send_word(OP_PIXEL, pix);
      end else begin
        if (noisy && $urandom_range(15) == 0) send_word(OP_PIXEL, PIX_W'($urandom));
        send_word(OP_FLUSH, PIX_W'($urandom));
      end
      words_sent++;
    end
    if (stop_at < total) begin
      settle();
      if ($urandom_range(1)) write_reg(CFG_IMAGE_WIDTH, width_val);
      else write_reg(CFG_IMAGE_HEIGHT, height_val);
    end
  endtask

  initial begin
    int  rw, rh;
    bit  broken;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_IMAGE_WIDTH;
    cfg_wdata_i  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_PIXEL;
    in_ch.pixel  <= '0;
    width_val  = int'(IMG_W_RST);
    height_val = int'(IMG_H_RST);
    words_sent = 0;
    set_idling(35, 82);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // narrow frame at the reset height, cut short after ten rows
    write_reg(CFG_IMAGE_WIDTH, 6);
    send_frame(NONE, 1'b0, 6 * 10, NONE);
    configure(3, 3);
    send_frame(255, 1'b0, NONE, NONE);
    send_frame(0, 1'b1, NONE, NONE);
    configure(0, 1);
    send_frame(NONE, 1'b0, NONE, NONE);
    configure(2, 2);
    send_frame(NONE, 1'b0, NONE, NONE);
    configure(4, 4);
    send_frame(NONE, 1'b0, NONE, 7);
    configure(5, 5);
    send_frame(NONE, 1'b1, NONE, NONE);
    configure(1, 2047);
    send_frame(NONE, 1'b0, 3 * 24, NONE);

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent >= 2 * RANDOM_WORDS / 3) set_idling(0, 0);
      else if (words_sent >= RANDOM_WORDS / 3) set_idling(82, 35);
      if (words_sent == 0 || $urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0:       rw = $urandom_range(0, 2);
          1:       rw = $urandom_range(13, 20);
          default: rw = $urandom_range(3, 12);
        endcase
        case ($urandom_range(9))
          0:       rh = $urandom_range(0, 2);
          1:       rh = $urandom_range(9, 12);
          default: rh = $urandom_range(3, 8);
        endcase
        configure(rw, rh);
      end
      broken = ($urandom_range(6) == 0);
      send_frame(NONE, broken || $urandom_range(3) == 0, broken ? ANYWHERE : NONE,
                 ($urandom_range(7) == 0) ? ANYWHERE : NONE);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
